/* sv/sei_pkg.sv */
package sei_pkg;

    localparam int MAX_EDGES = 32;
    localparam int IDX_W     = $clog2(MAX_EDGES);
    localparam int CNT_W     = $clog2(MAX_EDGES + 1);
    localparam int QUO_W     = 33;
    localparam int DEN_W     = 16;
    localparam int STEP_W    = $clog2(QUO_W + 1);

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_HORIZ = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_U = 2'd1,
        SEL_V = 2'd2,
        SEL_NA = 2'd3
    } sel_t;

    typedef struct packed {
        logic signed [15:0] x_start;
        logic signed [15:0] y_low;
        logic signed [15:0] y_high;
        logic signed [31:0] x_slope;
        logic [16:0]        u_start;
        logic signed [31:0] u_slope;
        logic [16:0]        v_start;
        logic signed [31:0] v_slope;
    } edge_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic [16:0]        u;
        logic [16:0]        v;
    } point_t;

    typedef struct packed {
        logic    latch;
        logic    count_clr;
        logic    count_inc;
        logic    mem_wr;
        logic    mem_rd;
        logic    q_init;
        logic    mul_en;
        logic    ins_en;
        logic    div_start;
        sel_t    sel;
        logic    slope_ld;
        logic    resp_ld;
        status_t resp_status;
        logic    emit_ld;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic horiz;
        logic full;
        logic count_zero;
        logic div_done;
        logic idx_last;
        logic n_zero;
        logic k_last;
    } stat_t;

endpackage

/* sv/scanline_edge_intersector.sv */
// Scanline edge table with u/v interpolation. A transaction is taken when start
// is high and busy is low; each result shows on the result ports for exactly one
// cycle with valid high, and last marks the final result of the transaction.
// The receiver cannot stall: it must take every result in the cycle it appears.
// Clear, unused codes and rejected adds (horizontal, table full) give one result,
// set in the decode state and then registered in the result register. An accepted
// add runs three serial divisions in a shared radix-2 divider of 33 steps each.
// A query reads the edge table one entry at a time (read, multiply,
// clamp-and-insert into the sorted buffer), then streams its N hits one per
// cycle. The edge table is a single-port memory; no clearing pass is needed
// after reset.
module scanline_edge_intersector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic signed [15:0] ax,
    input  logic signed [15:0] ay,
    input  logic [16:0]        au,
    input  logic [16:0]        av,
    input  logic signed [15:0] bx,
    input  logic signed [15:0] by,
    input  logic [16:0]        bu,
    input  logic [16:0]        bv,
    input  logic [10:0]        scan_y,
    output logic               valid,
    output logic [1:0]         status,
    output logic signed [15:0] point_x,
    output logic [10:0]        point_y,
    output logic [16:0]        point_u,
    output logic [16:0]        point_v,
    output logic               last
);
    import sei_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: decode, divide loop, table walk, result streaming
    sei_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // edge table, divider, interpolation and sorted point buffer
    sei_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req_type (req_type),
        .ax       (ax),
        .ay       (ay),
        .au       (au),
        .av       (av),
        .bx       (bx),
        .by       (by),
        .bu       (bu),
        .bv       (bv),
        .scan_y   (scan_y),
        .valid    (valid),
        .status   (status),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_u  (point_u),
        .point_v  (point_v),
        .last     (last)
    );

endmodule

/* sv/sei_div.sv */
module sei_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sei_pkg::QUO_W-1:0]  num,
    input  logic [sei_pkg::DEN_W-1:0]  den,
    output logic [sei_pkg::QUO_W-1:0]  quo,
    output logic                       done
);
    import sei_pkg::*;

    // restoring divider, one quotient bit per cycle
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    trial;

    assign trial = {rem_reg, quo_reg[QUO_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            cnt_next = STEP_W'(QUO_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

/* sv/sei_datapath.sv */
module sei_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sei_pkg::cmd_t       cmd,
    output sei_pkg::stat_t      stat,
    input  logic [1:0]          req_type,
    input  logic signed [15:0]  ax,
    input  logic signed [15:0]  ay,
    input  logic [16:0]         au,
    input  logic [16:0]         av,
    input  logic signed [15:0]  bx,
    input  logic signed [15:0]  by,
    input  logic [16:0]         bu,
    input  logic [16:0]         bv,
    input  logic [10:0]         scan_y,
    output logic                valid,
    output logic [1:0]          status,
    output logic signed [15:0]  point_x,
    output logic [10:0]         point_y,
    output logic [16:0]         point_u,
    output logic [16:0]         point_v,
    output logic                last
);
    import sei_pkg::*;

    // transaction registers
    logic [1:0]         req_reg;
    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [16:0]        au_reg, av_reg, bu_reg, bv_reg;
    logic [10:0]        sy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req_type;
            ax_reg  <= ax;
            ay_reg  <= ay;
            au_reg  <= au;
            av_reg  <= av;
            bx_reg  <= bx;
            by_reg  <= by;
            bu_reg  <= bu;
            bv_reg  <= bv;
            sy_reg  <= scan_y;
        end
    end

    // lower endpoint has the smaller y
    logic               a_low;
    logic signed [15:0] lx, ly, hx, hy;
    logic [16:0]        lu, lv, hu, hv;
    logic signed [17:0] dx, du, dv, diff;
    logic [16:0]        dmag;
    logic [15:0]        dy_mag;
    logic [QUO_W-1:0]   quo;
    logic               div_done;

    assign a_low = ay_reg < by_reg;
    assign lx = a_low ? ax_reg : bx_reg;
    assign ly = a_low ? ay_reg : by_reg;
    assign lu = a_low ? au_reg : bu_reg;
    assign lv = a_low ? av_reg : bv_reg;
    assign hx = a_low ? bx_reg : ax_reg;
    assign hy = a_low ? by_reg : ay_reg;
    assign hu = a_low ? bu_reg : au_reg;
    assign hv = a_low ? bv_reg : av_reg;

    assign dx = 18'(lx) - 18'(hx);
    assign du = $signed({1'b0, lu}) - $signed({1'b0, hu});
    assign dv = $signed({1'b0, lv}) - $signed({1'b0, hv});

    always_comb
    begin
        unique case (cmd.sel)
            SEL_X:   diff = dx;
            SEL_U:   diff = du;
            SEL_V:   diff = dv;
            default: diff = '0;
        endcase
    end

    assign dmag   = diff[17] ? 17'(-diff) : diff[16:0];
    assign dy_mag = 16'(17'(hy) - 17'(ly));

    sei_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ({dmag, 16'd0}),
        .den   (dy_mag),
        .quo   (quo),
        .done  (div_done)
    );

    // dy is always negative, so the slope is negative when diff is positive
    sel_t               dsel_reg;
    logic               neg_reg;
    logic signed [31:0] slope_val;
    logic signed [31:0] xs_reg, us_reg, vs_reg;

    always_comb
    begin
        if (!neg_reg)
        begin
            slope_val = (quo > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
        end
        else
        begin
            slope_val = (quo >= 33'h0_8000_0000) ? 32'sh8000_0000
                                                 : $signed(32'(-quo[31:0]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dsel_reg <= cmd.sel;
            neg_reg  <= !diff[17] && (diff != '0);
        end
        if (cmd.slope_ld)
        begin
            unique case (dsel_reg)
                SEL_X:   xs_reg <= slope_val;
                SEL_U:   us_reg <= slope_val;
                SEL_V:   vs_reg <= slope_val;
                default: ;
            endcase
        end
    end

    // edge table
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] idx_reg;
    edge_t            edge_mem [MAX_EDGES];
    edge_t            rd_reg;
    edge_t            wr_entry;

    always_comb
    begin
        wr_entry.x_start = lx;
        wr_entry.y_low   = ly;
        wr_entry.y_high  = hy;
        wr_entry.x_slope = xs_reg;
        wr_entry.u_start = lu;
        wr_entry.u_slope = us_reg;
        wr_entry.v_start = lv;
        wr_entry.v_slope = vs_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            edge_mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (cmd.mem_rd)
        begin
            rd_reg <= edge_mem[idx_reg];
        end
    end

    // span test and slope products
    logic signed [16:0] yq, ylo, yhi, d;
    logic               hit;
    logic signed [48:0] px_next, pu_next, pv_next;
    logic signed [48:0] px_reg, pu_reg, pv_reg;
    logic signed [15:0] sx_reg;
    logic [16:0]        su_reg, sv_reg;
    logic               hit_reg;

    assign yq  = $signed({2'b00, sy_reg, 4'b0000});
    assign ylo = 17'(rd_reg.y_low);
    assign yhi = 17'(rd_reg.y_high);
    assign hit = (yq >= ylo) && (yq <= yhi);
    assign d   = yq - ylo;

    assign px_next = 49'(rd_reg.x_slope) * 49'($signed({1'b0, d[15:0]}));
    assign pu_next = 49'(rd_reg.u_slope) * 49'($signed({1'b0, d[15:0]}));
    assign pv_next = 49'(rd_reg.v_slope) * 49'($signed({1'b0, d[15:0]}));

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            px_reg <= px_next;
            pu_reg <= pu_next;
            pv_reg <= pv_next;
            sx_reg <= rd_reg.x_start;
            su_reg <= rd_reg.u_start;
            sv_reg <= rd_reg.v_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.mul_en)
        begin
            hit_reg <= hit;
        end
    end

    // floor shift, add start, clamp
    logic signed [33:0] qx, qu, qv;
    point_t             pnew;

    assign qx = 34'(sx_reg) + 34'($signed(px_reg[48:16]));
    assign qu = $signed({17'd0, su_reg}) + 34'($signed(pu_reg[48:16]));
    assign qv = $signed({17'd0, sv_reg}) + 34'($signed(pv_reg[48:16]));

    always_comb
    begin
        if (qx < -34'sd32768)
            pnew.x = -16'sd32768;
        else if (qx > 34'sd32767)
            pnew.x = 16'sd32767;
        else
            pnew.x = qx[15:0];
        if (qu < 34'sd0)
            pnew.u = '0;
        else if (qu > 34'sd65536)
            pnew.u = 17'd65536;
        else
            pnew.u = qu[16:0];
        if (qv < 34'sd0)
            pnew.v = '0;
        else if (qv > 34'sd65536)
            pnew.v = 17'd65536;
        else
            pnew.v = qv[16:0];
    end

    // sorted point buffer: every slot compares against the new point at once
    point_t           pbuf [MAX_EDGES];
    point_t           pbuf_next [MAX_EDGES];
    logic             gt [MAX_EDGES];
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] k_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_EDGES; j++)
        begin
            gt[j] = (CNT_W'(j) < n_reg) && (pbuf[j].x > pnew.x);
        end
        for (int j = 0; j < MAX_EDGES; j++)
        begin
            if (j > 0 && gt[(j > 0) ? j - 1 : 0])
                pbuf_next[j] = pbuf[(j > 0) ? j - 1 : 0];
            else if (gt[j] || CNT_W'(j) == n_reg)
                pbuf_next[j] = pnew;
            else
                pbuf_next[j] = pbuf[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_en && hit_reg)
        begin
            for (int j = 0; j < MAX_EDGES; j++)
            begin
                pbuf[j] <= pbuf_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            n_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (cmd.count_clr)
                count_reg <= '0;
            else if (cmd.count_inc)
                count_reg <= count_reg + 1'b1;
            if (cmd.q_init)
            begin
                idx_reg <= '0;
                n_reg   <= '0;
                k_reg   <= '0;
            end
            else
            begin
                if (cmd.ins_en)
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (hit_reg)
                        n_reg <= n_reg + 1'b1;
                end
                if (cmd.emit_ld)
                    k_reg <= k_reg + 1'b1;
            end
        end
    end

    // result register
    logic               valid_reg;
    logic [1:0]         status_reg;
    logic signed [15:0] x_reg;
    logic [10:0]        y_reg;
    logic [16:0]        u_reg, v_reg;
    logic               last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.resp_ld || cmd.emit_ld;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_ld)
        begin
            status_reg <= cmd.resp_status;
            x_reg      <= '0;
            y_reg      <= (cmd.resp_status == ST_EMPTY) ? sy_reg : '0;
            u_reg      <= '0;
            v_reg      <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.emit_ld)
        begin
            status_reg <= ST_OK;
            x_reg      <= pbuf[k_reg].x;
            y_reg      <= sy_reg;
            u_reg      <= pbuf[k_reg].u;
            v_reg      <= pbuf[k_reg].v;
            last_reg   <= stat.k_last;
        end
    end

    assign valid   = valid_reg;
    assign status  = status_reg;
    assign point_x = x_reg;
    assign point_y = y_reg;
    assign point_u = u_reg;
    assign point_v = v_reg;
    assign last    = last_reg;

    assign stat.req        = req_t'(req_reg);
    assign stat.horiz      = (ay_reg == by_reg);
    assign stat.full       = (count_reg >= CNT_W'(MAX_EDGES));
    assign stat.count_zero = (count_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.idx_last   = (CNT_W'(idx_reg) + 1'b1) == count_reg;
    assign stat.n_zero     = (n_reg == '0);
    assign stat.k_last     = (CNT_W'(k_reg) + 1'b1) == n_reg;

endmodule

/* sv/sei_ctrl.sv */
module sei_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  sei_pkg::stat_t stat,
    output sei_pkg::cmd_t  cmd
);
    import sei_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_WRITE  = 8'b0000_1000,
        S_QRD    = 8'b0001_0000,
        S_QMUL   = 8'b0010_0000,
        S_QINS   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    sel_t   sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                sel_next = SEL_X;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.req)
                    REQ_CLEAR:
                    begin
                        cmd.count_clr   = 1'b1;
                        cmd.resp_ld     = 1'b1;
                        cmd.resp_status = ST_OK;
                        state_next      = S_IDLE;
                    end
                    REQ_ADD:
                    begin
                        priority if (stat.horiz)
                        begin
                            cmd.resp_ld     = 1'b1;
                            cmd.resp_status = ST_HORIZ;
                            state_next      = S_IDLE;
                        end
                        else if (stat.full)
                        begin
                            cmd.resp_ld     = 1'b1;
                            cmd.resp_status = ST_FULL;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.sel       = SEL_X;
                            state_next    = S_DIV;
                        end
                    end
                    REQ_QUERY:
                    begin
                        cmd.q_init = 1'b1;
                        state_next = stat.count_zero ? S_EMIT : S_QRD;
                    end
                    default:
                    begin
                        cmd.resp_ld     = 1'b1;
                        cmd.resp_status = ST_OK;
                        state_next      = S_IDLE;
                    end
                endcase
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.slope_ld = 1'b1;
                    if (sel_reg == SEL_V)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        sel_next      = (sel_reg == SEL_X) ? SEL_U : SEL_V;
                        cmd.sel       = sel_next;
                        cmd.div_start = 1'b1;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.mem_wr      = 1'b1;
                cmd.count_inc   = 1'b1;
                cmd.resp_ld     = 1'b1;
                cmd.resp_status = ST_OK;
                state_next      = S_IDLE;
            end
            S_QRD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_QMUL;
            end
            S_QMUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_QINS;
            end
            S_QINS:
            begin
                cmd.ins_en = 1'b1;
                state_next = stat.idx_last ? S_EMIT : S_QRD;
            end
            S_EMIT:
            begin
                if (stat.n_zero)
                begin
                    cmd.resp_ld     = 1'b1;
                    cmd.resp_status = ST_EMPTY;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.emit_ld = 1'b1;
                    if (stat.k_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_X;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* sv/sei_checker.sv */
module sei_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         req_type,
    input logic signed [15:0] ax,
    input logic signed [15:0] ay,
    input logic [16:0]        au,
    input logic [16:0]        av,
    input logic signed [15:0] bx,
    input logic signed [15:0] by,
    input logic [16:0]        bu,
    input logic [16:0]        bv,
    input logic [10:0]        scan_y,
    input logic               valid,
    input logic [1:0]         status,
    input logic signed [15:0] point_x,
    input logic [10:0]        point_y,
    input logic [16:0]        point_u,
    input logic [16:0]        point_v,
    input logic               last
);
    import sei_pkg::*;

    // an accepted transaction holds the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // query results stream without gaps until last
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |=> valid)
        else $error("gap in result stream");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |-> busy)
        else $error("idle while results remain");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status != ST_OK) |-> last)
        else $error("non-ok result not final");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (status == ST_EMPTY) |-> (point_x == '0) && (point_u == '0)
            && (point_v == '0))
        else $error("empty query carries data");

endmodule

bind scanline_edge_intersector sei_checker u_sei_checker (.*);
